>>> hdl/lda_pkg.sv
// ----------------------------------------------------------------------------
// lda_pkg
// Shared widths, codes, controller/datapath interface types and the pixel
// rounding function of the DDA line rasterizer.
// ----------------------------------------------------------------------------
package lda_pkg;

  // Coordinate and fixed point widths.
  localparam int COORD_W = 10;
  localparam int FRAC_W  = 16;
  localparam int ACC_W   = COORD_W + FRAC_W + 1;
  localparam int INC_W   = FRAC_W + 2;
  localparam int STEP_W  = COORD_W + 1;
  localparam int CNT_W   = $clog2(FRAC_W + 1);

  localparam logic [CNT_W-1:0] DIV_LAST_CNT = CNT_W'(FRAC_W);
  localparam logic [COORD_W-1:0] COORD_MAX  = {COORD_W{1'b1}};

  typedef enum logic {
    OP_BEGIN   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start_div;
    logic div_step;
    logic finish;
    logic advance;
  } lda_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
    logic out_valid;
  } lda_sts_t;

  // Rounds a fixed point accumulator to a pixel as floor(acc + 0.5),
  // saturating to the coordinate range.
  function automatic logic [COORD_W-1:0] round_coord(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0] v;
    logic [COORD_W+1:0]    p;
    v = $signed({acc[ACC_W-1], acc}) + $signed((ACC_W + 1)'(1) << (FRAC_W - 1));
    p = v[ACC_W:FRAC_W];
    if (v[ACC_W]) begin
      round_coord = '0;
    end else if (p[COORD_W+1:COORD_W] != 2'b00) begin
      round_coord = COORD_MAX;
    end else begin
      round_coord = p[COORD_W-1:0];
    end
  endfunction

endpackage

>>> hdl/lda_datapath.sv
// ----------------------------------------------------------------------------
// lda_datapath
// Accumulators, increments, the two-lane radix-2 divider and the output
// register of the DDA line rasterizer.
// ----------------------------------------------------------------------------
module lda_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lda_pkg::lda_cmd_t          cmd,
  output lda_pkg::lda_sts_t          sts,
  input  logic [lda_pkg::COORD_W-1:0] in_x_start,
  input  logic [lda_pkg::COORD_W-1:0] in_y_start,
  input  logic [lda_pkg::COORD_W-1:0] in_x_finish,
  input  logic [lda_pkg::COORD_W-1:0] in_y_finish,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [lda_pkg::COORD_W-1:0] out_pixel_x,
  output logic [lda_pkg::COORD_W-1:0] out_pixel_y,
  output logic                       out_last,
  output logic                       out_valid_res
);
  import lda_pkg::*;

  logic signed [ACC_W-1:0]  x_acc_r, y_acc_r, x_acc_nxt, y_acc_nxt;
  logic signed [INC_W-1:0]  x_inc_r, y_inc_r, x_inc_fin, y_inc_fin;
  logic [STEP_W-1:0]        steps_r, steps_left_r;
  logic                     line_active_r;
  logic [STEP_W-1:0]        x_rem_r, y_rem_r;
  logic [FRAC_W:0]          x_q_r, y_q_r;
  logic                     x_neg_r, y_neg_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     out_valid_r, out_last_r, out_valid_res_r;
  logic [COORD_W-1:0]       out_pixel_x_r, out_pixel_y_r;

  logic signed [STEP_W-1:0] x_dx, y_dx;
  logic [STEP_W-1:0]        x_adx, y_adx, steps_max;
  logic                     x_ge, y_ge;
  logic [STEP_W-1:0]        x_diff, y_diff;
  logic                     zero_len, adv_last;

  // Operand setup for a begin transaction.
  assign x_dx      = $signed({1'b0, in_x_finish}) - $signed({1'b0, in_x_start});
  assign y_dx      = $signed({1'b0, in_y_finish}) - $signed({1'b0, in_y_start});
  assign x_adx     = x_dx[STEP_W-1] ? STEP_W'(-x_dx) : STEP_W'(x_dx);
  assign y_adx     = y_dx[STEP_W-1] ? STEP_W'(-y_dx) : STEP_W'(y_dx);
  assign steps_max = (x_adx > y_adx) ? x_adx : y_adx;

  // One restoring division step per lane; the remainder is stored pre-shifted.
  assign x_ge   = (x_rem_r >= steps_r);
  assign y_ge   = (y_rem_r >= steps_r);
  assign x_diff = x_ge ? (x_rem_r - steps_r) : x_rem_r;
  assign y_diff = y_ge ? (y_rem_r - steps_r) : y_rem_r;

  assign x_inc_fin = x_neg_r ? -$signed({1'b0, x_q_r}) : $signed({1'b0, x_q_r});
  assign y_inc_fin = y_neg_r ? -$signed({1'b0, y_q_r}) : $signed({1'b0, y_q_r});
  assign zero_len  = (steps_r == '0);

  assign x_acc_nxt = x_acc_r + {{(ACC_W-INC_W){x_inc_r[INC_W-1]}}, x_inc_r};
  assign y_acc_nxt = y_acc_r + {{(ACC_W-INC_W){y_inc_r[INC_W-1]}}, y_inc_r};
  assign adv_last  = (steps_left_r == STEP_W'(1));

  // Divider and operand registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.start_div) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      steps_r <= steps_max;
      x_rem_r <= x_adx;
      y_rem_r <= y_adx;
      x_q_r   <= '0;
      y_q_r   <= '0;
      x_neg_r <= x_dx[STEP_W-1];
      y_neg_r <= y_dx[STEP_W-1];
    end else if (cmd.div_step) begin
      x_rem_r <= {x_diff[STEP_W-2:0], 1'b0};
      y_rem_r <= {y_diff[STEP_W-2:0], 1'b0};
      x_q_r   <= {x_q_r[FRAC_W-1:0], x_ge};
      y_q_r   <= {y_q_r[FRAC_W-1:0], y_ge};
    end
  end

  // Line state.
  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      x_acc_r <= $signed({1'b0, in_x_start, {FRAC_W{1'b0}}});
      y_acc_r <= $signed({1'b0, in_y_start, {FRAC_W{1'b0}}});
    end else if (cmd.advance && line_active_r) begin
      x_acc_r <= x_acc_nxt;
      y_acc_r <= y_acc_nxt;
    end
    if (cmd.finish) begin
      x_inc_r <= zero_len ? '0 : x_inc_fin;
      y_inc_r <= zero_len ? '0 : y_inc_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r <= 1'b0;
      steps_left_r  <= '0;
    end else if (cmd.start_div) begin
      line_active_r <= 1'b0;
    end else if (cmd.finish) begin
      line_active_r <= !zero_len;
      steps_left_r  <= steps_r;
    end else if (cmd.advance && line_active_r) begin
      line_active_r <= !adv_last;
      steps_left_r  <= steps_left_r - STEP_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish || cmd.advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_pixel_x_r   <= round_coord(x_acc_r);
      out_pixel_y_r   <= round_coord(y_acc_r);
      out_last_r      <= zero_len;
      out_valid_res_r <= 1'b1;
    end else if (cmd.advance) begin
      if (line_active_r) begin
        out_pixel_x_r   <= round_coord(x_acc_nxt);
        out_pixel_y_r   <= round_coord(y_acc_nxt);
        out_last_r      <= adv_last;
        out_valid_res_r <= 1'b1;
      end else begin
        out_pixel_x_r   <= '0;
        out_pixel_y_r   <= '0;
        out_last_r      <= 1'b0;
        out_valid_res_r <= 1'b0;
      end
    end
  end

  assign sts.div_last  = (cnt_r == DIV_LAST_CNT);
  assign sts.out_valid = out_valid_r;

  assign out_valid     = out_valid_r;
  assign out_pixel_x   = out_pixel_x_r;
  assign out_pixel_y   = out_pixel_y_r;
  assign out_last      = out_last_r;
  assign out_valid_res = out_valid_res_r;

endmodule

>>> hdl/lda_ctrl.sv
// ----------------------------------------------------------------------------
// lda_ctrl
// Controller of the DDA line rasterizer: sequences the divider on a begin
// transaction and issues single-cycle advances.
// ----------------------------------------------------------------------------
module lda_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  lda_pkg::op_t      in_operation,
  output logic              in_ready,
  input  logic              out_ready,
  input  lda_pkg::lda_sts_t sts,
  output lda_pkg::lda_cmd_t cmd
);
  import lda_pkg::*;

  state_t state_r, state_nxt;
  logic   in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    // The output slot is free when empty or being drained in this cycle.
    in_ready  = (state_r == ST_IDLE) && (!sts.out_valid || out_ready);
    in_fire   = in_valid && in_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_operation == OP_BEGIN) begin
            cmd.start_div = 1'b1;
            state_nxt     = ST_DIVIDE;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/line_dda_rasterizer_top.sv
// ----------------------------------------------------------------------------
// line_dda_rasterizer_top
// Fixed point DDA line rasterizer: a begin transaction loads two endpoints and
// returns the start pixel, each advance transaction returns the next pixel.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Payload
//   in_      in_valid / in_ready  in_operation, in_x_start, in_y_start,
//                                 in_x_finish, in_y_finish
//   out_     out_valid/out_ready  out_pixel_x, out_pixel_y, out_last,
//                                 out_valid_res
//
// Advance transactions stream pixels at one per cycle while out_ready stays high.
// A begin transaction runs the radix-2 divider, which produces one quotient
// bit per cycle for both axes at once; a finish step then loads the
// increments and the start pixel into the output register.
// rst_n is synchronous and active low; it leaves the block idle with no line.
// A stalled out_ready holds the pending result. in_ready stays low only while
// the divider runs or finishes, or while a result waits and is not taken.
//
module line_dda_rasterizer_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  logic [lda_pkg::COORD_W-1:0] in_x_start,
  input  logic [lda_pkg::COORD_W-1:0] in_y_start,
  input  logic [lda_pkg::COORD_W-1:0] in_x_finish,
  input  logic [lda_pkg::COORD_W-1:0] in_y_finish,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lda_pkg::COORD_W-1:0] out_pixel_x,
  output logic [lda_pkg::COORD_W-1:0] out_pixel_y,
  output logic                        out_last,
  output logic                        out_valid_res
);
  import lda_pkg::*;

  // Command and status between the controller and the datapath.
  lda_cmd_t cmd;
  lda_sts_t sts;
  op_t      op;

  assign op = op_t'(in_operation);

  // The controller decides when a transaction is taken and steps the divider.
  lda_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (op),
    .in_ready     (in_ready),
    .out_ready    (out_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // The datapath holds the line state and the registered result.
  lda_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_x_start    (in_x_start),
    .in_y_start    (in_y_start),
    .in_x_finish   (in_x_finish),
    .in_y_finish   (in_y_finish),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_last      (out_last),
    .out_valid_res (out_valid_res)
  );

endmodule

>>> hdl/lda_checker.sv
// ----------------------------------------------------------------------------
// lda_checker
// Port-level checks of the DDA line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module lda_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_operation,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lda_pkg::COORD_W-1:0] out_pixel_x,
  input logic [lda_pkg::COORD_W-1:0] out_pixel_y,
  input logic                        out_last,
  input logic                        out_valid_res
);
  import lda_pkg::*;

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_x) &&
      $stable(out_pixel_y) && $stable(out_last) && $stable(out_valid_res))
    else $error("result changed while stalled");

  // An advance without an active line returns an all-zero result.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> !out_last && out_pixel_x == '0 &&
      out_pixel_y == '0)
    else $error("invalid result carries data");

  // A begin transaction occupies the divider in the next cycle.
  a_begin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_BEGIN |=> !in_ready && !out_valid)
    else $error("begin did not hold off input");

  // An advance transaction produces its result in the next cycle.
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_ADVANCE |=> out_valid)
    else $error("advance result missing");

endmodule

bind line_dda_rasterizer_top lda_checker u_lda_checker (.*);
